[rtl/core/lcdst_pkg.sv]
// ----------------------------------------------------------------------------
// lcdst_pkg
// Types and constants shared by the scanline timing and status core.
// ----------------------------------------------------------------------------
package lcdst_pkg;

  // field widths
  localparam int CYCLES_W = 6;
  localparam int LINE_W   = 8;
  localparam int LEFT_W   = 9;
  localparam int STATEN_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // line numbers and mode timing
  localparam logic [LINE_W-1:0] LAST_LINE   = 8'd153;
  localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
  localparam int OAM_CYCLES  = 80;
  localparam int XFER_CYCLES = 172;

  // bit of the interrupt enables for the line compare source
  localparam int STAT_EN_LYC_BIT = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LCD_ENABLE = 2'd0,
    CFG_LYC        = 2'd1,
    CFG_STAT_EN    = 2'd2
  } cfg_index_t;

  // display mode codes
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  // configuration register set
  typedef struct packed {
    logic                lcd_enable;
    logic [LINE_W-1:0]   lyc;
    logic [STATEN_W-1:0] stat_en;
  } cfg_t;

  // one result
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [1:0]        mode;
    logic              coincidence;
    logic              draw_line;
    logic              vblank_irq;
    logic              stat_irq;
    logic              in_vblank;
  } line_result_t;

endpackage

[rtl/core/lcdst_if.sv]
// ----------------------------------------------------------------------------
// lcdst_if
// Valid/ready channels for tick requests and timing results.
// ----------------------------------------------------------------------------
interface lcdst_tick_if;
  logic       valid;
  logic       ready;
  logic [5:0] cycles;

  modport source (output valid, output cycles, input ready);
  modport sink   (input valid, input cycles, output ready);
endinterface

interface lcdst_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] line;
  logic [1:0] mode;
  logic       coincidence;
  logic       draw_line;
  logic       vblank_irq;
  logic       stat_irq;
  logic       in_vblank;

  modport source (output valid, output line, output mode, output coincidence,
                  output draw_line, output vblank_irq, output stat_irq,
                  output in_vblank, input ready);
  modport sink   (input valid, input line, input mode, input coincidence,
                  input draw_line, input vblank_irq, input stat_irq,
                  input in_vblank, output ready);
endinterface

[rtl/core/lcdst_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lcdst_cfg_regs
// Configuration registers: display enable, line compare value, irq enables.
// ----------------------------------------------------------------------------
module lcdst_cfg_regs
  import lcdst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t regs;

  // register writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LCD_ENABLE: regs.lcd_enable <= cfg_data[0];
        CFG_LYC:        regs.lyc        <= cfg_data[LINE_W-1:0];
        CFG_STAT_EN:    regs.stat_en    <= cfg_data[STATEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[rtl/core/lcdst_line_timer.sv]
// ----------------------------------------------------------------------------
// lcdst_line_timer
// Line countdown, line counter, mode and status state with one-tick update.
// ----------------------------------------------------------------------------
module lcdst_line_timer
  import lcdst_pkg::*;
#(
  parameter int LINE_CYCLES = 456
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [CYCLES_W-1:0] cycles,
  input  cfg_t                cfg,
  output line_result_t        result
);

  localparam logic [LEFT_W-1:0] LINE_LEN = LEFT_W'(LINE_CYCLES);
  localparam logic [LEFT_W-1:0] OAM_TH   = LEFT_W'(LINE_CYCLES - OAM_CYCLES);
  localparam logic [LEFT_W-1:0] XFER_TH  =
    LEFT_W'(LINE_CYCLES - OAM_CYCLES - XFER_CYCLES);

  logic [LEFT_W-1:0] line_cycles_left, line_cycles_left_next;
  logic [LINE_W-1:0] current_line, current_line_next;
  lcd_mode_t         line_mode, line_mode_next;
  logic              vblank_flag, vblank_flag_next;
  logic              coin_flag, coin_flag_next;

  logic signed [LEFT_W:0] diff;
  logic                   wrap;
  logic [LINE_W-1:0]      line_inc;
  logic                   draw, vbirq, stirq;

  // countdown, line advance and mode derivation
  always_comb begin
    line_cycles_left_next = line_cycles_left;
    current_line_next     = current_line;
    line_mode_next        = line_mode;
    vblank_flag_next      = vblank_flag;
    coin_flag_next        = coin_flag;
    draw                  = 1'b0;
    vbirq                 = 1'b0;
    stirq                 = 1'b0;

    diff     = $signed({1'b0, line_cycles_left}) -
               $signed({{(LEFT_W + 1 - CYCLES_W){1'b0}}, cycles});
    wrap     = (diff <= 0);
    line_inc = current_line + LINE_W'(1);

    if (cfg.lcd_enable) begin
      line_cycles_left_next = diff[LEFT_W-1:0];
      if (wrap) begin
        line_cycles_left_next = diff[LEFT_W-1:0] + LINE_LEN;
        current_line_next     = line_inc;
        if (line_inc > LAST_LINE) begin
          current_line_next = '0;
          vblank_flag_next  = 1'b0;
        end
        if (current_line_next < VBLANK_LINE) begin
          draw = 1'b1;
        end else if (current_line_next == VBLANK_LINE) begin
          vbirq            = 1'b1;
          vblank_flag_next = 1'b1;
        end
      end

      // mode from line and remaining cycles
      if (current_line_next > VBLANK_LINE) begin
        line_mode_next = MODE_VBLANK;
      end else if (line_cycles_left_next > OAM_TH) begin
        line_mode_next = MODE_OAM;
      end else if (line_cycles_left_next > XFER_TH) begin
        line_mode_next = MODE_XFER;
      end else begin
        line_mode_next = MODE_HBLANK;
      end

      // status interrupt on enabled mode change, transfer excluded
      if (line_mode_next != line_mode && line_mode_next != MODE_XFER &&
          cfg.stat_en[line_mode_next]) begin
        stirq = 1'b1;
      end

      // line compare
      coin_flag_next = (cfg.lyc == current_line_next);
      if (coin_flag_next && cfg.stat_en[STAT_EN_LYC_BIT]) begin
        stirq = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_cycles_left <= LINE_LEN;
      current_line     <= '0;
      line_mode        <= MODE_HBLANK;
      vblank_flag      <= 1'b0;
      coin_flag        <= 1'b0;
    end else if (step) begin
      line_cycles_left <= line_cycles_left_next;
      current_line     <= current_line_next;
      line_mode        <= line_mode_next;
      vblank_flag      <= vblank_flag_next;
      coin_flag        <= coin_flag_next;
    end
  end

  // result of this tick
  always_comb begin
    result.line        = current_line_next;
    result.mode        = line_mode_next;
    result.coincidence = coin_flag_next;
    result.draw_line   = draw;
    result.vblank_irq  = vbirq;
    result.stat_irq    = stirq;
    result.in_vblank   = vblank_flag_next;
  end

endmodule

[rtl/core/lcd_scanline_timing_stat_core.sv]
// ----------------------------------------------------------------------------
// lcd_scanline_timing_stat_core
// Scanline timing and status unit: line countdown, mode and interrupts.
// ----------------------------------------------------------------------------
// a tick request is held in the tick register, and its result then in the result register
// throughput: one tick per cycle while the result side takes each result, set by the
// state update between the tick register and the result register
// reset: synchronous, clears configuration, timing state and both stages
module lcd_scanline_timing_stat_core
  import lcdst_pkg::*;
#(
  parameter int LINE_CYCLES = 456
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lcdst_tick_if.sink            tick,
  lcdst_result_if.source        result
);

  cfg_t                cfg;
  logic                tick_valid;
  logic [CYCLES_W-1:0] tick_cycles;
  logic                out_valid;
  line_result_t        out_data;
  line_result_t        step_result;
  logic                advance;

  // configuration registers
  lcdst_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: the tick stage moves on when the result register is free
  assign advance    = tick_valid && (!out_valid || result.ready);
  assign tick.ready = !tick_valid || advance;

  // tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      tick_cycles <= tick.cycles;
    end
  end

  // timing state and update
  lcdst_line_timer #(
    .LINE_CYCLES (LINE_CYCLES)
  ) u_line_timer (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cycles (tick_cycles),
    .cfg    (cfg),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign result.valid       = out_valid;
  assign result.line        = out_data.line;
  assign result.mode        = out_data.mode;
  assign result.coincidence = out_data.coincidence;
  assign result.draw_line   = out_data.draw_line;
  assign result.vblank_irq  = out_data.vblank_irq;
  assign result.stat_irq    = out_data.stat_irq;
  assign result.in_vblank   = out_data.in_vblank;

endmodule

[tb/lcd_scanline_timing_stat_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_scanline_timing_stat_core_tb
// Drives tick requests into the scanline timing core and checks every result
// against a cycle-count predictor of line, mode, coincidence and interrupts.
// A short directed run covers display off, zero ticks, exact line ends and
// the oam/transfer boundary. The random phases that follow run through many
// lines with fresh register settings in each phase. Both channels idle and
// stall at random, with a stretch of phases that runs at full rate.
// ----------------------------------------------------------------------------
module lcd_scanline_timing_stat_core_tb;
  import lcdst_pkg::*;

  localparam int LINE_CYCLES = 456;
  localparam int LATENCY     = 2;
  localparam int IDLE_PCT    = 8;
  localparam int STALL_LIMIT = 1000;
  // enabled random requests, sized to the overall request budget
  localparam int RANDOM_TICKS = 810;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // predictor of the line timing state and queue of expected line status
  class scanline_scoreboard;
    int                  line_len;
    bit                  disp_on;
    logic [LINE_W-1:0]   lyc_line;
    logic [STATEN_W-1:0] irq_en;
    int                  cycles_left;
    logic [LINE_W-1:0]   cur_line;
    lcd_mode_t           cur_mode;
    bit                  vblank_flag;
    bit                  coin_flag;
    line_result_t        expected_status[$];
    int                  errors;

    function new(int len);
      line_len    = len;
      disp_on     = 1'b0;
      lyc_line    = '0;
      irq_en      = '0;
      cycles_left = len;
      cur_line    = '0;
      cur_mode    = MODE_HBLANK;
      vblank_flag = 1'b0;
      coin_flag   = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LCD_ENABLE: disp_on  = val[0];
        CFG_LYC:        lyc_line = val;
        CFG_STAT_EN:    irq_en   = val[STATEN_W-1:0];
        default: ;
      endcase
    endfunction

    // mode from the line number and the position within the line
    function lcd_mode_t mode_at_position();
      if (cur_line > VBLANK_LINE)
        return MODE_VBLANK;
      if (cycles_left > line_len - OAM_CYCLES)
        return MODE_OAM;
      if (cycles_left > line_len - OAM_CYCLES - XFER_CYCLES)
        return MODE_XFER;
      return MODE_HBLANK;
    endfunction

    // advance the timing by one accepted request and queue its status
    function void note_tick(logic [CYCLES_W-1:0] cycles);
      line_result_t want;
      lcd_mode_t    next_mode;
      want = '0;
      if (disp_on) begin
        cycles_left -= int'(cycles);
        // end of line: reload and step the line number
        if (cycles_left <= 0) begin
          cycles_left += line_len;
          if (cur_line >= LAST_LINE) begin
            cur_line    = '0;
            vblank_flag = 1'b0;
          end else begin
            cur_line = cur_line + LINE_W'(1);
          end
          if (cur_line < VBLANK_LINE) begin
            want.draw_line = 1'b1;
          end else if (cur_line == VBLANK_LINE) begin
            want.vblank_irq = 1'b1;
            vblank_flag     = 1'b1;
          end
        end
        // status interrupt on an enabled mode change, transfer never counts
        next_mode = mode_at_position();
        if (next_mode != cur_mode && next_mode != MODE_XFER && irq_en[next_mode])
          want.stat_irq = 1'b1;
        cur_mode = next_mode;
        // line compare, raised on every tick while it holds
        coin_flag = (lyc_line == cur_line);
        if (coin_flag && irq_en[STAT_EN_LYC_BIT])
          want.stat_irq = 1'b1;
      end
      want.line        = cur_line;
      want.mode        = cur_mode;
      want.coincidence = coin_flag;
      want.in_vblank   = vblank_flag;
      expected_status.push_back(want);
    endfunction

    function void check_field(string fname, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_status(line_result_t got);
      line_result_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: result with nothing expected, line %0d mode %0d",
                 $time, got.line, got.mode);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      check_field("line", want.line, got.line);
      check_field("mode", 8'(want.mode), 8'(got.mode));
      check_field("coincidence", 8'(want.coincidence), 8'(got.coincidence));
      check_field("draw_line", 8'(want.draw_line), 8'(got.draw_line));
      check_field("vblank_irq", 8'(want.vblank_irq), 8'(got.vblank_irq));
      check_field("stat_irq", 8'(want.stat_irq), 8'(got.stat_irq));
      check_field("in_vblank", 8'(want.in_vblank), 8'(got.in_vblank));
    endfunction

    function int pending();
      return expected_status.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    steady;
  int                    enabled_ticks;

  lcdst_tick_if   tick_ch();
  lcdst_result_if result_ch();

  scanline_scoreboard sb = new(LINE_CYCLES);

  lcd_scanline_timing_stat_core #(
    .LINE_CYCLES(LINE_CYCLES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tick     (tick_ch),
    .result   (result_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_status(line_result_t'{
        line:        result_ch.line,
        mode:        result_ch.mode,
        coincidence: result_ch.coincidence,
        draw_line:   result_ch.draw_line,
        vblank_irq:  result_ch.vblank_irq,
        stat_irq:    result_ch.stat_irq,
        in_vblank:   result_ch.in_vblank});
  end

  // watchdog on cycles with no request or result moving
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("[lcd_scanline_timing_stat_core] ERROR");
    $finish;
  end

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // all three registers, with junk in the unused upper bits
  task automatic set_registers(input logic en, input logic [7:0] lyc_val,
                               input logic [3:0] irq_val);
    logic [6:0] junk;
    junk = 7'($urandom);
    write_reg(CFG_LCD_ENABLE, {junk, en});
    write_reg(CFG_LYC, lyc_val);
    write_reg(CFG_STAT_EN, {junk[3:0], irq_val});
    cfg_we <= 1'b0;
  endtask

  // one tick request, with a random gap before it
  task automatic send_tick(input logic [CYCLES_W-1:0] cycles);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid  <= 1'b1;
    tick_ch.cycles <= cycles;
    if (sb.disp_on)
      enabled_ticks++;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(cycles);
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic settle();
    tick_ch.valid <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // mostly large ticks so that lines turn over quickly, the rest over the full range
  function automatic logic [CYCLES_W-1:0] pick_cycles();
    if ($urandom_range(3) != 0)
      return CYCLES_W'($urandom_range(63, 52));
    return CYCLES_W'($urandom_range(63, 0));
  endfunction

  // compare line near the current one, at the frame edges, or anywhere
  function automatic logic [7:0] pick_lyc();
    case ($urandom_range(5))
      0:       return sb.cur_line + 8'($urandom_range(2));
      1:       return 8'd0;
      2:       return VBLANK_LINE;
      3:       return LAST_LINE;
      4:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [3:0] pick_irq_en();
    case ($urandom_range(3))
      0:       return 4'hF;
      1:       return 4'h0;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // stimulus
  initial begin
    logic [CYCLES_W-1:0] directed_ticks [23];
    int                  phase;
    int                  phase_len;
    logic                en;
    directed_ticks = '{6'd0, 6'd63, 6'd63, 6'd63, 6'd63, 6'd1, 6'd63, 6'd63, 6'd63,
                       6'd42, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd50,
                       6'd0, 6'd63, 6'd17, 6'd32, 6'd16, 6'd1};
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_LCD_ENABLE;
    cfg_data       <= '0;
    tick_ch.valid  <= 1'b0;
    tick_ch.cycles <= '0;
    steady         = 1'b0;
    enabled_ticks  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // display off out of reset: ticks hold everything
    send_tick(6'd63);
    send_tick(6'd0);
    settle();

    // write to an unknown index has no effect
    write_reg(CFG_UNUSED, 8'hFF);
    // every source enabled, compare on line 0; zero tick, exact line end,
    // oam to transfer boundary
    set_registers(1'b1, 8'd0, 4'hF);
    foreach (directed_ticks[i])
      send_tick(directed_ticks[i]);
    settle();

    // display switched off mid-line
    set_registers(1'b0, 8'd2, 4'h5);
    send_tick(6'd63);
    send_tick(6'd21);
    settle();

    // random phases, each with its own register setting
    enabled_ticks = 0;
    phase = 0;
    while (enabled_ticks < RANDOM_TICKS) begin
      en        = ($urandom_range(9) != 0);
      steady    = (phase >= 4 && phase < 8);
      set_registers(en, pick_lyc(), pick_irq_en());
      phase_len = en ? $urandom_range(120, 30) : $urandom_range(12, 4);
      repeat (phase_len) send_tick(pick_cycles());
      settle();
      phase++;
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("[lcd_scanline_timing_stat_core] OK");
    else
      $display("[lcd_scanline_timing_stat_core] ERROR");
    $finish;
  end

endmodule
